### src/assert_macros.svh
// Assertion macros used by the covariance block's top-level module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CGM_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("cgm assertion failed");
`define CGM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cgm assertion failed");
`else
`define CGM_ASSERT(lbl, cond)
`define CGM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### src/cgm_pkg.sv
// Types, widths and codes of the covariance matrix block.
package cgm_pkg;

  localparam int REG_W    = 7;
  localparam int SAMPLE_W = 8;
  localparam int INDEX_W  = 6;
  localparam int OUT_W    = 40;
  localparam int DEN_W    = 3 * REG_W;

  localparam int DEF_MAX_VECTORS   = 64;
  localparam int DEF_MAX_LENGTH    = 64;
  localparam int DEF_FRACTION_BITS = 16;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic CFG_LENGTH = 1'b0;
  localparam logic CFG_COUNT  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_RANGE      = 2'd1,
    ST_INCOMPLETE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_ACC,
    S_DRAIN,
    S_DIV,
    S_OUT
  } state_t;

endpackage

### src/cgm_in_if.sv
// Input channel: sample loads and entry reads.
interface cgm_in_if;
  logic                            valid;
  logic                            ready;
  logic                            kind;
  logic [cgm_pkg::SAMPLE_W-1:0]    sample_value;
  logic                            start_new_set;
  logic [cgm_pkg::INDEX_W-1:0]     row_index;
  logic [cgm_pkg::INDEX_W-1:0]     col_index;

  modport source (output valid, kind, sample_value, start_new_set, row_index, col_index,
                  input ready);
  modport sink (input valid, kind, sample_value, start_new_set, row_index, col_index,
                output ready);
endinterface

### src/cgm_out_if.sv
// Result channel: one matrix entry per read.
interface cgm_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [cgm_pkg::OUT_W-1:0]  entry_value;
  logic                              gram_of_vectors;
  logic [1:0]                        status;

  modport source (output valid, entry_value, gram_of_vectors, status, input ready);
  modport sink (input valid, entry_value, gram_of_vectors, status, output ready);
endinterface

### src/covariance_gram_matrix.sv
// Sample covariance / Gram matrix block, top level.
// Input channel in_ch carries two kinds of transaction. A load (kind 0) stores
// one 8-bit element of the current sample set and updates its element sum; it
// gives no result. A read (kind 1) returns one entry of the centered product
// matrix scaled by 1/(N-1) on out_ch, in signed fixed point.
// A valid read runs K multiply-accumulate steps (K = D for the N-by-N Gram
// matrix, N for the D-by-D covariance), one per cycle from the two read ports
// of the sample RAM; the pipeline then drains and the divider makes one
// quotient bit per cycle. Reads that fail a status check skip the accumulation
// and the divider and go straight to the output register.
// The user must write D or N on the configuration port while idle; the block
// does not enforce this. Any write restarts loading. Reset clears the load
// position and the complete flag and sets D and N to 64; the RAM is not cleared.
// The result waits in an output register; loads proceed while it is stalled,
// and a further read holds in its last state until that register is free.
module covariance_gram_matrix #(
  parameter int MAX_VECTORS   = cgm_pkg::DEF_MAX_VECTORS,
  parameter int MAX_LENGTH    = cgm_pkg::DEF_MAX_LENGTH,
  parameter int FRACTION_BITS = cgm_pkg::DEF_FRACTION_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  cgm_in_if.sink                     in_ch,
  cgm_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_index,
  input  logic [cgm_pkg::REG_W-1:0]  cfg_data
);
`include "assert_macros.svh"

  localparam int DEPTH = MAX_VECTORS * MAX_LENGTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int VW    = $clog2(MAX_VECTORS);
  localparam int SUM_W = $clog2(MAX_VECTORS * 255 + 1);
  localparam int CW    = SUM_W + 1;
  localparam int KMAX  = (MAX_VECTORS > MAX_LENGTH) ? MAX_VECTORS : MAX_LENGTH;
  localparam int KW    = $clog2(KMAX + 1);
  localparam int ACC_W = 2 * CW + KW;
  localparam int NUM_W = ACC_W + FRACTION_BITS;
  localparam int CMP_W = (NUM_W > cgm_pkg::OUT_W + 1) ? NUM_W : cgm_pkg::OUT_W + 1;
  localparam int RW    = cgm_pkg::REG_W;
  localparam int DW    = cgm_pkg::DEN_W;

  cgm_pkg::state_t state_r, state_nxt;

  logic [RW-1:0] len_r, cnt_cfg_r;
  logic [RW-1:0] d_eff, n_eff, size;
  logic          gram;

  logic [AW-1:0] pos_r;
  logic [VW-1:0] vec_r;
  logic [EW-1:0] elem_r;
  logic          complete_r;

  logic [AW-1:0] pos_e;
  logic [VW-1:0] vec_e;
  logic [EW-1:0] elem_e;
  logic          last_elem, last_vec;

  logic [EW-1:0]           ld_elem_r;
  logic                    ld_first_r;
  logic [SUM_W-1:0]        ld_val_r;

  logic [AW-1:0]  addr_a_r, addr_b_r, stride_r;
  logic [EW-1:0]  sum_a_r, sum_b_r;
  logic           sum_step_r;
  logic [KW-1:0]  steps_r;
  logic [2:0]     pv_r;

  logic [CW-1:0]            ca_r, cb_r;
  logic signed [2*CW-1:0]   prod_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic [2*RW-1:0] nn_r;
  logic [DW-1:0]   den_r;

  cgm_pkg::status_t status_e, res_status_r;
  logic             res_gram_r;
  logic             neg_r;

  logic in_fire, in_ready, out_free;
  logic store_we, sums_we, issue, div_start, div_busy;

  logic [AW-1:0]        store_ra, store_rb;
  logic [EW-1:0]        sums_ra, sums_rb;
  logic [7:0]           x_a, x_b;
  logic [SUM_W-1:0]     s_a, s_b;
  logic [SUM_W-1:0]     sums_wdata;
  logic [ACC_W-1:0]     mag;
  logic [NUM_W-1:0]     num, quo;
  logic [CMP_W-1:0]     qx, lim, sat;
  logic [cgm_pkg::OUT_W-1:0] value_e;

  // Effective D and N, saturated into their legal ranges.
  always_comb begin
    d_eff = len_r;
    if (len_r == '0) begin
      d_eff = RW'(1);
    end else if (32'(len_r) > MAX_LENGTH) begin
      d_eff = RW'(MAX_LENGTH);
    end
    n_eff = cnt_cfg_r;
    if (cnt_cfg_r < RW'(2)) begin
      n_eff = RW'(2);
    end else if (32'(cnt_cfg_r) > MAX_VECTORS) begin
      n_eff = RW'(MAX_VECTORS);
    end
  end

  assign gram = d_eff > n_eff;
  assign size = gram ? n_eff : d_eff;

  assign in_fire  = in_ch.valid && in_ready;
  assign out_free = !out_ch.valid || out_ch.ready;

  always_comb begin
    if (!complete_r) begin
      status_e = cgm_pkg::ST_INCOMPLETE;
    end else if (RW'(in_ch.row_index) >= size || RW'(in_ch.col_index) >= size) begin
      status_e = cgm_pkg::ST_RANGE;
    end else begin
      status_e = cgm_pkg::ST_OK;
    end
  end

  // Load position after an optional restart.
  assign pos_e     = in_ch.start_new_set ? '0 : pos_r;
  assign vec_e     = in_ch.start_new_set ? '0 : vec_r;
  assign elem_e    = in_ch.start_new_set ? '0 : elem_r;
  assign last_elem = 32'(elem_e) == 32'(d_eff) - 1;
  assign last_vec  = 32'(vec_e) == 32'(n_eff) - 1;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cgm_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_ch.kind == cgm_pkg::KIND_LOAD) begin
            state_nxt = cgm_pkg::S_LOAD;
          end else if (status_e != cgm_pkg::ST_OK) begin
            state_nxt = cgm_pkg::S_OUT;
          end else begin
            state_nxt = cgm_pkg::S_ACC;
          end
        end
      end
      cgm_pkg::S_LOAD:  state_nxt = cgm_pkg::S_IDLE;
      cgm_pkg::S_ACC: begin
        if (steps_r == KW'(1)) begin
          state_nxt = cgm_pkg::S_DRAIN;
        end
      end
      cgm_pkg::S_DRAIN: begin
        if (pv_r == '0) begin
          state_nxt = cgm_pkg::S_DIV;
        end
      end
      cgm_pkg::S_DIV: begin
        if (!div_busy) begin
          state_nxt = cgm_pkg::S_OUT;
        end
      end
      cgm_pkg::S_OUT: begin
        if (out_free) begin
          state_nxt = cgm_pkg::S_IDLE;
        end
      end
      default: state_nxt = cgm_pkg::S_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    in_ready  = 1'b0;
    store_we  = 1'b0;
    sums_we   = 1'b0;
    issue     = 1'b0;
    div_start = 1'b0;
    case (state_r)
      cgm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        store_we = in_ch.valid && in_ch.kind == cgm_pkg::KIND_LOAD;
      end
      cgm_pkg::S_LOAD:  sums_we   = 1'b1;
      cgm_pkg::S_ACC:   issue     = 1'b1;
      cgm_pkg::S_DRAIN: div_start = pv_r == '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cgm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration and load position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= RW'(64);
      cnt_cfg_r  <= RW'(64);
      pos_r      <= '0;
      vec_r      <= '0;
      elem_r     <= '0;
      complete_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        cgm_pkg::CFG_LENGTH: len_r     <= cfg_data;
        cgm_pkg::CFG_COUNT:  cnt_cfg_r <= cfg_data;
        default: ;
      endcase
      pos_r      <= '0;
      vec_r      <= '0;
      elem_r     <= '0;
      complete_r <= 1'b0;
    end else if (in_fire && in_ch.kind == cgm_pkg::KIND_LOAD) begin
      if (last_elem && last_vec) begin
        pos_r      <= '0;
        vec_r      <= '0;
        elem_r     <= '0;
        complete_r <= 1'b1;
      end else begin
        pos_r <= pos_e + 1'b1;
        if (pos_e == '0) begin
          complete_r <= 1'b0;
        end
        if (last_elem) begin
          elem_r <= '0;
          vec_r  <= vec_e + 1'b1;
        end else begin
          elem_r <= elem_e + 1'b1;
          vec_r  <= vec_e;
        end
      end
    end
  end

  // Hold the load for the sum update.
  always_ff @(posedge clk) begin
    if (in_fire && in_ch.kind == cgm_pkg::KIND_LOAD) begin
      ld_elem_r  <= elem_e;
      ld_first_r <= vec_e == '0;
      ld_val_r   <= SUM_W'(in_ch.sample_value);
    end
  end

  assign sums_wdata = ld_first_r ? ld_val_r : s_a + ld_val_r;

  // Read addresses and step count.
  always_ff @(posedge clk) begin
    if (in_fire && in_ch.kind == cgm_pkg::KIND_READ) begin
      res_status_r <= status_e;
      res_gram_r   <= gram;
      sum_step_r   <= gram;
      if (gram) begin
        addr_a_r <= AW'(32'(in_ch.row_index) * 32'(d_eff));
        addr_b_r <= AW'(32'(in_ch.col_index) * 32'(d_eff));
        stride_r <= AW'(1);
        sum_a_r  <= '0;
        sum_b_r  <= '0;
        steps_r  <= KW'(d_eff);
      end else begin
        addr_a_r <= AW'(in_ch.row_index);
        addr_b_r <= AW'(in_ch.col_index);
        stride_r <= AW'(d_eff);
        sum_a_r  <= EW'(in_ch.row_index);
        sum_b_r  <= EW'(in_ch.col_index);
        steps_r  <= KW'(n_eff);
      end
    end else if (issue) begin
      addr_a_r <= addr_a_r + stride_r;
      addr_b_r <= addr_b_r + stride_r;
      sum_a_r  <= sum_a_r + EW'(sum_step_r);
      sum_b_r  <= sum_b_r + EW'(sum_step_r);
      steps_r  <= steps_r - 1'b1;
    end
  end

  assign store_ra = addr_a_r;
  assign store_rb = addr_b_r;
  assign sums_ra  = (state_r == cgm_pkg::S_ACC) ? sum_a_r : elem_e;
  assign sums_rb  = sum_b_r;

  cgm_ram #(.WIDTH(cgm_pkg::SAMPLE_W), .DEPTH(DEPTH)) u_store (
    .clk     (clk),
    .we      (store_we),
    .waddr   (pos_e),
    .wdata   (in_ch.sample_value),
    .raddr_a (store_ra),
    .raddr_b (store_rb),
    .rdata_a (x_a),
    .rdata_b (x_b)
  );

  cgm_ram #(.WIDTH(SUM_W), .DEPTH(MAX_LENGTH)) u_sums (
    .clk     (clk),
    .we      (sums_we),
    .waddr   (ld_elem_r),
    .wdata   (sums_wdata),
    .raddr_a (sums_ra),
    .raddr_b (sums_rb),
    .rdata_a (s_a),
    .rdata_b (s_b)
  );

  // Multiply-accumulate pipeline: center, multiply, add.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else begin
      pv_r <= {pv_r[1:0], issue};
    end
  end

  always_ff @(posedge clk) begin
    ca_r   <= CW'(n_eff) * CW'(x_a) - CW'(s_a);
    cb_r   <= CW'(n_eff) * CW'(x_b) - CW'(s_b);
    prod_r <= $signed(ca_r) * $signed(cb_r);
    if (in_fire && in_ch.kind == cgm_pkg::KIND_READ) begin
      acc_r <= '0;
    end else if (pv_r[2]) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // Denominator N*N*(N-1), settled well before the divider starts.
  always_ff @(posedge clk) begin
    nn_r  <= (2*RW)'(n_eff) * (2*RW)'(n_eff);
    den_r <= DW'(nn_r) * DW'(n_eff - 1'b1);
  end

  assign mag = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign num = (NUM_W'(mag) << FRACTION_BITS) + NUM_W'(den_r >> 1);

  always_ff @(posedge clk) begin
    if (div_start) begin
      neg_r <= acc_r[ACC_W-1];
    end
  end

  cgm_div #(.NUM_W(NUM_W), .DEN_W(DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .den   (den_r),
    .busy  (div_busy),
    .quo   (quo)
  );

  // Saturate to the signed output range.
  always_comb begin
    qx  = CMP_W'(quo);
    lim = CMP_W'(1) << (cgm_pkg::OUT_W - 1);
    if (neg_r) begin
      sat = (qx > lim) ? lim : qx;
    end else begin
      sat = (qx > lim - 1'b1) ? lim - 1'b1 : qx;
    end
    value_e = neg_r ? cgm_pkg::OUT_W'(-sat) : cgm_pkg::OUT_W'(sat);
  end

  // Output register.
  logic                              out_valid_r;
  logic signed [cgm_pkg::OUT_W-1:0]  out_value_r;
  logic                              out_gram_r;
  cgm_pkg::status_t                  out_status_r;
  logic                              out_load;

  assign out_load = state_r == cgm_pkg::S_OUT && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r  <= (res_status_r == cgm_pkg::ST_OK) ? value_e : '0;
      out_gram_r   <= res_gram_r;
      out_status_r <= res_status_r;
    end
  end

  assign in_ch.ready            = in_ready;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.entry_value     = out_value_r;
  assign out_ch.gram_of_vectors = out_gram_r;
  assign out_ch.status          = out_status_r;

  `CGM_ASSERT(a_pipe_in_read, pv_r == '0 || state_r == cgm_pkg::S_ACC || state_r == cgm_pkg::S_DRAIN)
  `CGM_ASSERT(a_div_idle_start, !(div_start && div_busy))
  `CGM_ASSERT(a_pos_in_set, 32'(pos_r) < 32'(n_eff) * 32'(d_eff))
  `CGM_ASSERT_NEXT(a_out_loaded, out_load, out_valid_r)

endmodule

### src/cgm_ram.sv
// Generic RAM: one write port, two registered read ports.
module cgm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                       rdata_a,
  output logic [WIDTH-1:0]                       rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

### src/cgm_div.sv
// Restoring divider, one quotient bit per cycle.
module cgm_div #(
  parameter int NUM_W = 55,
  parameter int DEN_W = 21
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [NUM_W-1:0] q_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W:0]   shifted;
  logic             ge;

  assign shifted = {rem_r, q_r[NUM_W-1]};
  assign ge      = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(NUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= {q_r[NUM_W-2:0], ge};
      rem_r <= ge ? DEN_W'(shifted - {1'b0, den}) : DEN_W'(shifted);
    end
  end

  assign busy = busy_r;
  assign quo  = q_r;
endmodule
